[sv/b64e_pkg.sv]
`timescale 1ns / 1ps
package b64e_pkg;

  // ASCII codes used by the encoder
  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'
  localparam logic [7:0] UPPER_A    = 8'h41;  // 'A'
  localparam logic [7:0] LOWER_A    = 8'h61;  // 'a'
  localparam logic [7:0] DIGIT_0    = 8'h30;  // '0'

  // Held byte counts
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Character positions within a group of four
  localparam logic [1:0] IDX_FIRST = 2'd0;
  localparam logic [1:0] IDX_LAST  = 2'd3;

  // Group queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // One group of up to three bytes, msb first, missing bytes zero
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  cnt;   // bytes held before the closing byte (0..2)
    logic        last;  // group ends the message
  } group_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic       busy;
    logic [1:0] idx;
  } back_stat_t;

  // Map a sextet to the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26) begin
        b64_char = UPPER_A + w;
      end else if (v < 6'd52) begin
        b64_char = LOWER_A + (w - 8'd26);
      end else if (v < 6'd62) begin
        b64_char = DIGIT_0 + (w - 8'd52);
      end else if (v == 6'd62) begin
        b64_char = PLUS_CHAR;
      end else begin
        b64_char = SLASH_CHAR;
      end
    end
  endfunction

endpackage

[sv/b64e_in_if.sv]
`timescale 1ns / 1ps
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

[sv/b64e_out_if.sv]
`timescale 1ns / 1ps
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[sv/b64e_front.sv]
`timescale 1ns / 1ps
module b64e_front (
  input  logic            clk,
  input  logic            rst,
  b64e_in_if.sink         bytes,
  output logic            push_valid,
  input  logic            push_ready,
  output b64e_pkg::group_t push_data
);
  import b64e_pkg::*;

  logic [7:0] held_bytes [2];
  logic [1:0] held_count;
  logic       transfer;
  logic       closes;

  // Accept whenever the queue has room for a possible group
  assign bytes.ready = push_ready;
  assign transfer    = bytes.valid && push_ready;
  assign closes      = (held_count == CNT_TWO) || bytes.end_of_message;
  assign push_valid  = bytes.valid && closes;

  // Assemble the group, msb first
  always_comb begin
    push_data.cnt  = held_count;
    push_data.last = bytes.end_of_message;
    unique case (held_count)
      CNT_NONE: push_data.bits = {bytes.data_byte, 16'h0000};
      CNT_ONE:  push_data.bits = {held_bytes[0], bytes.data_byte, 8'h00};
      default:  push_data.bits = {held_bytes[0], held_bytes[1], bytes.data_byte};
    endcase
  end

  // Hold bytes until a group closes
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= CNT_NONE;
    end else if (transfer) begin
      if (closes) begin
        held_count <= CNT_NONE;
      end else begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (transfer && !closes) begin
      held_bytes[held_count[0]] <= bytes.data_byte;
    end
  end

endmodule

[sv/b64e_queue.sv]
`timescale 1ns / 1ps
module b64e_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_valid,
  output logic                        push_ready,
  input  b64e_pkg::group_t            push_data,
  output logic                        pop_valid,
  input  logic                        pop,
  output b64e_pkg::group_t            pop_data,
  output logic [b64e_pkg::QCNT_W-1:0] fill
);
  import b64e_pkg::*;

  group_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign fill       = count;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the group
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/b64e_back.sv]
`timescale 1ns / 1ps
module b64e_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop,
  input  b64e_pkg::group_t     pop_data,
  b64e_out_if.source           chars,
  output b64e_pkg::back_stat_t stat
);
  import b64e_pkg::*;

  group_t     grp;
  logic       busy;
  logic [1:0] idx;
  logic       transfer;
  logic [5:0] sextet;
  logic       present;

  assign transfer = busy && chars.ready;
  assign pop      = pop_valid && (!busy || (chars.ready && idx == IDX_LAST));

  // Walk the four characters of the current group
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_FIRST;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= IDX_FIRST;
    end else if (transfer) begin
      idx <= idx + 2'd1;
      if (idx == IDX_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= pop_data;
    end
  end

  // Select the sextet and decide on padding
  always_comb begin
    case (idx)
      2'd0:    sextet = grp.bits[23:18];
      2'd1:    sextet = grp.bits[17:12];
      2'd2:    sextet = grp.bits[11:6];
      default: sextet = grp.bits[5:0];
    endcase
  end

  assign present = ({1'b0, idx} <= ({1'b0, grp.cnt} + 3'd1));

  assign chars.valid     = busy;
  assign chars.out_char  = present ? b64_char(sextet) : PAD_CHAR;
  assign chars.last_char = grp.last && (idx == IDX_LAST);

  assign stat.busy = busy;
  assign stat.idx  = idx;

endmodule

[sv/base64_stream_encoder.sv]
`timescale 1ns / 1ps
// A closing byte passes through the group queue and the back end's group register
// before its first character appears. Bytes are taken one per cycle while the queue
// has room; the back end sends one character per cycle while the output is ready,
// four per group. A two-entry group queue lets intake run ahead of the character stream.
// Reset (rst, synchronous, active high) empties the held bytes, the queue and the back end.
module base64_stream_encoder (
  input  logic        clk,
  input  logic        rst,
  b64e_in_if.sink     bytes,
  b64e_out_if.source  chars
);
  import b64e_pkg::*;

  logic              push_valid;
  logic              push_ready;
  group_t            push_data;
  logic              pop_valid;
  logic              pop;
  group_t            pop_data;
  logic [QCNT_W-1:0] fill;
  back_stat_t        stat;

  // Classify bytes and close groups
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Buffer closed groups
  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data),
    .fill       (fill)
  );

  // Emit characters
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .chars     (chars),
    .stat      (stat)
  );

  // Queue never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("group queue overfilled");

  // Output valid follows the back end's busy flag
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    chars.valid == stat.busy)
    else $error("output valid apart from back-end busy");

  // Last flag only on the fourth character
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.last_char) |-> (stat.idx == IDX_LAST))
    else $error("last_char away from fourth character");

  // Padding only on the third or fourth character
  a_pad_pos: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.out_char == PAD_CHAR) |-> (stat.idx[1] == 1'b1))
    else $error("padding in leading characters");

  // A group, once started, keeps its characters coming
  a_group_cont: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready && stat.idx != IDX_LAST) |=> chars.valid)
    else $error("group cut short");

endmodule
